/* sv/adam_optimizer_update_core_macros.svh */
// Assertion helpers used by the adam_ctrl RTL file.
`ifndef ADAM_OPTIMIZER_UPDATE_CORE_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_CORE_MACROS_SVH

// same-cycle implication
`define ADAM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ADAM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/adam_pkg.sv */
package adam_pkg;

  localparam int NumWeights = 1024;
  localparam int IdxW       = 10;
  localparam int DivSteps   = 48;
  localparam int SqrtSteps  = 32;

  typedef struct packed {
    logic signed [31:0] gradient;
    logic [IdxW-1:0]    weight_index;
    logic               advance_step;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] update_value;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] beta_first;
    logic [15:0] beta_second;
    logic [15:0] epsilon;
  } cfg_t;

  // register map indexes
  localparam logic [1:0] REG_BETA_FIRST  = 2'd0;
  localparam logic [1:0] REG_BETA_SECOND = 2'd1;
  localparam logic [1:0] REG_EPSILON     = 2'd2;

  // datapath operations
  localparam logic [4:0] OP_IDLE = 5'd0;
  localparam logic [4:0] OP_CLR  = 5'd1;
  localparam logic [4:0] OP_LOAD = 5'd2;
  localparam logic [4:0] OP_PW1  = 5'd3;
  localparam logic [4:0] OP_PW2  = 5'd4;
  localparam logic [4:0] OP_PW3  = 5'd5;
  localparam logic [4:0] OP_RD   = 5'd6;
  localparam logic [4:0] OP_MA   = 5'd7;
  localparam logic [4:0] OP_MB   = 5'd8;
  localparam logic [4:0] OP_MC   = 5'd9;
  localparam logic [4:0] OP_MD   = 5'd10;
  localparam logic [4:0] OP_ME   = 5'd11;
  localparam logic [4:0] OP_MF   = 5'd12;
  localparam logic [4:0] OP_DM   = 5'd13;
  localparam logic [4:0] OP_DV   = 5'd14;
  localparam logic [4:0] OP_SQ   = 5'd15;
  localparam logic [4:0] OP_DQ   = 5'd16;
  localparam logic [4:0] OP_FIN  = 5'd17;

  typedef struct packed {
    logic [4:0]      op;
    logic [IdxW-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic adv;
    logic div_done;
    logic sqrt_done;
  } stat_t;

endpackage

/* sv/adam_div.sv */
module adam_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic        done,
  output logic        over,
  output logic [47:0] quot
);
  import adam_pkg::*;

  logic [32:0] rem;
  logic [32:0] den;
  logic [47:0] lo;
  logic [5:0]  cnt;
  logic        busy;
  logic [33:0] shifted;
  logic [34:0] diff;
  logic        fits;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, lo[47]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign fits    = !diff[34];
  assign quot    = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(DivSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {17'b0, dividend[63:48]};
      lo   <= dividend[47:0];
      den  <= divisor;
      over <= {17'b0, dividend[63:48]} >= divisor;
      cnt  <= '0;
    end else if (busy) begin
      rem <= fits ? diff[32:0] : shifted[32:0];
      lo  <= {lo[46:0], fits};
      cnt <= cnt + 6'd1;
    end
  end

endmodule

/* sv/adam_sqrt.sv */
module adam_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import adam_pkg::*;

  logic [63:0] xs;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [34:0] cur;
  logic [34:0] trial;
  logic [35:0] diff;
  logic        fits;

  // two radicand bits per cycle, one root bit
  assign cur   = {rem[32:0], xs[63:62]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = {1'b0, cur} - {1'b0, trial};
  assign fits  = !diff[35];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'(SqrtSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      xs   <= {xs[61:0], 2'b00};
      rem  <= fits ? diff[33:0] : cur[33:0];
      root <= {root[30:0], fits};
      cnt  <= cnt + 5'd1;
    end
  end

endmodule

/* sv/adam_dp.sv */
module adam_dp (
  input  logic              clk,
  input  logic              rst,
  input  adam_pkg::cfg_t    cfg,
  input  adam_pkg::cmd_t    cmd,
  input  adam_pkg::in_beat_t in_data,
  output adam_pkg::stat_t   stat,
  output adam_pkg::out_beat_t out_data
);
  import adam_pkg::*;

  localparam logic signed [33:0] MMax   = 34'sd2147483647;
  localparam logic signed [33:0] MMin   = -34'sd2147483648;
  localparam logic [47:0]        HatMax = 48'hFFFF_FFFF_FFFF;

  logic [31:0] mem_m [NumWeights];
  logic [31:0] mem_v [NumWeights];

  logic signed [31:0] grad;
  logic [IdxW-1:0]    idx;
  logic               adv;
  logic [31:0]        p1, p2;
  logic [31:0]        m_rd, v_rd;
  logic signed [63:0] prod;
  logic signed [49:0] acc;
  logic signed [31:0] m_new;
  logic [31:0]        gsq, v_new;
  logic [47:0]        mh;
  logic               sat, dz;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [16:0]        omb1, omb2;
  logic [31:0]        gmag, mmag;
  logic [48:0]        pw_sum;
  logic signed [49:0] m_sum;
  logic signed [33:0] m_sh;
  logic [63:0]        gsq_sum;
  logic [49:0]        v_sum;
  logic [32:0]        c1, c2, d_sum;
  logic [47:0]        hat_val;

  logic               div_start, div_done, div_over;
  logic [63:0]        div_num;
  logic [32:0]        div_den;
  logic [47:0]        div_q;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;

  logic               m_we, v_we;
  logic [IdxW-1:0]    waddr;
  logic [31:0]        m_wd, v_wd;

  assign omb1    = 17'h1_0000 - {1'b0, cfg.beta_first};
  assign omb2    = 17'h1_0000 - {1'b0, cfg.beta_second};
  assign gmag    = grad[31] ? 32'(-grad) : grad;
  assign mmag    = m_new[31] ? 32'(-m_new) : m_new;
  assign c1      = 33'h1_0000_0000 - {1'b0, p1};
  assign c2      = 33'h1_0000_0000 - {1'b0, p2};
  assign d_sum   = {1'b0, sq_root} + {17'b0, cfg.epsilon};
  assign hat_val = div_over ? HatMax : div_q;

  assign pw_sum  = {1'b0, prod[47:0]} + 49'd32768;
  assign m_sum   = acc + $signed(prod[49:0]) + 50'sd32768;
  assign m_sh    = m_sum[49:16];
  assign gsq_sum = prod + 64'd32768;
  assign v_sum   = acc + prod[49:0] + 50'd32768;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_PW1: begin mul_a = {1'b0, p1}; mul_b = {17'b0, cfg.beta_first}; end
      OP_PW2: begin mul_a = {1'b0, p2}; mul_b = {17'b0, cfg.beta_second}; end
      OP_MA:  begin mul_a = {17'b0, cfg.beta_first}; mul_b = {m_rd[31], m_rd}; end
      OP_MB:  begin mul_a = {16'b0, omb1}; mul_b = {grad[31], grad}; end
      OP_MC:  begin mul_a = {1'b0, gmag}; mul_b = {1'b0, gmag}; end
      OP_MD:  begin mul_a = {17'b0, cfg.beta_second}; mul_b = {1'b0, v_rd}; end
      OP_ME:  begin mul_a = {16'b0, omb2}; mul_b = {1'b0, gsq}; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      OP_DM: begin div_start = 1'b1; div_num = {mmag, 32'b0}; div_den = c1; end
      OP_DV: begin div_start = 1'b1; div_num = {v_new, 32'b0}; div_den = c2; end
      OP_DQ: begin div_start = 1'b1; div_num = {mh, 16'b0}; div_den = d_sum; end
      default: ;
    endcase
  end
  assign sq_start = cmd.op == OP_SQ;

  // moment store write port
  always_comb begin
    m_we  = 1'b0;
    v_we  = 1'b0;
    waddr = idx;
    m_wd  = m_new;
    v_wd  = v_new;
    case (cmd.op)
      OP_CLR: begin m_we = 1'b1; v_we = 1'b1; waddr = cmd.clr_addr; m_wd = '0; v_wd = '0; end
      OP_MD:  m_we = 1'b1;
      OP_DM:  v_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_we) mem_m[waddr] <= m_wd;
    if (v_we) mem_v[waddr] <= v_wd;
    if (cmd.op == OP_RD) begin
      m_rd <= mem_m[idx];
      v_rd <= mem_v[idx];
    end
  end

  // beta powers
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '1;
      p2 <= '1;
    end else begin
      if (cmd.op == OP_PW2) p1 <= pw_sum[47:16];
      if (cmd.op == OP_PW3) p2 <= pw_sum[47:16];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p[63:0];
    case (cmd.op)
      OP_LOAD: begin
        grad <= in_data.gradient;
        idx  <= in_data.weight_index;
        adv  <= in_data.advance_step;
        sat  <= 1'b0;
      end
      OP_MB, OP_ME: acc <= prod[49:0];
      OP_MC: begin
        if (m_sh > MMax) begin
          m_new <= 32'sh7FFF_FFFF;
          sat   <= 1'b1;
        end else if (m_sh < MMin) begin
          m_new <= 32'sh8000_0000;
          sat   <= 1'b1;
        end else begin
          m_new <= m_sh[31:0];
        end
      end
      OP_MD: begin
        if (gsq_sum[63:48] != '0) begin
          gsq <= '1;
          sat <= 1'b1;
        end else begin
          gsq <= gsq_sum[47:16];
        end
      end
      OP_MF: begin
        if (v_sum[49:48] != '0) begin
          v_new <= '1;
          sat   <= 1'b1;
        end else begin
          v_new <= v_sum[47:16];
        end
      end
      OP_DV: begin
        mh  <= hat_val;
        sat <= sat | div_over;
      end
      OP_SQ: sat <= sat | div_over;
      OP_DQ: dz  <= d_sum == '0;
      OP_FIN: begin
        if (dz) begin
          out_data.update_value <= '0;
          out_data.saturated    <= 1'b0;
        end else if (m_new[31]) begin
          if (div_over || div_q > 48'h0000_8000_0000) begin
            out_data.update_value <= 32'sh8000_0000;
            out_data.saturated    <= 1'b1;
          end else begin
            out_data.update_value <= 32'(-div_q[31:0]);
            out_data.saturated    <= sat;
          end
        end else begin
          if (div_over || div_q > 48'h0000_7FFF_FFFF) begin
            out_data.update_value <= 32'sh7FFF_FFFF;
            out_data.saturated    <= 1'b1;
          end else begin
            out_data.update_value <= div_q[31:0];
            out_data.saturated    <= sat;
          end
        end
      end
      default: ;
    endcase
  end

  adam_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .over     (div_over),
    .quot     (div_q)
  );

  adam_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ({hat_val, 16'b0}),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign stat.adv       = adv;
  assign stat.div_done  = div_done;
  assign stat.sqrt_done = sq_done;

endmodule

/* sv/adam_ctrl.sv */
`include "adam_optimizer_update_core_macros.svh"

module adam_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  adam_pkg::stat_t stat,
  output adam_pkg::cmd_t  cmd
);
  import adam_pkg::*;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_PW1   = 5'd2;
  localparam logic [4:0] S_PW2   = 5'd3;
  localparam logic [4:0] S_PW3   = 5'd4;
  localparam logic [4:0] S_RD    = 5'd5;
  localparam logic [4:0] S_MA    = 5'd6;
  localparam logic [4:0] S_MB    = 5'd7;
  localparam logic [4:0] S_MC    = 5'd8;
  localparam logic [4:0] S_MD    = 5'd9;
  localparam logic [4:0] S_ME    = 5'd10;
  localparam logic [4:0] S_MF    = 5'd11;
  localparam logic [4:0] S_DM    = 5'd12;
  localparam logic [4:0] S_WDM   = 5'd13;
  localparam logic [4:0] S_WDV   = 5'd14;
  localparam logic [4:0] S_WSQ   = 5'd15;
  localparam logic [4:0] S_WDQ   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;

  logic [4:0]      state, state_next;
  logic [IdxW-1:0] clr_cnt;
  logic            out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next   = state;
    cmd.op       = OP_IDLE;
    cmd.clr_addr = clr_cnt;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (clr_cnt == IdxW'(NumWeights - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_PW1;
        end
      end
      S_PW1: begin
        if (stat.adv) begin
          cmd.op     = OP_PW1;
          state_next = S_PW2;
        end else begin
          cmd.op     = OP_RD;
          state_next = S_MA;
        end
      end
      S_PW2: begin cmd.op = OP_PW2; state_next = S_PW3; end
      S_PW3: begin cmd.op = OP_PW3; state_next = S_RD;  end
      S_RD:  begin cmd.op = OP_RD;  state_next = S_MA;  end
      S_MA:  begin cmd.op = OP_MA;  state_next = S_MB;  end
      S_MB:  begin cmd.op = OP_MB;  state_next = S_MC;  end
      S_MC:  begin cmd.op = OP_MC;  state_next = S_MD;  end
      S_MD:  begin cmd.op = OP_MD;  state_next = S_ME;  end
      S_ME:  begin cmd.op = OP_ME;  state_next = S_MF;  end
      S_MF:  begin cmd.op = OP_MF;  state_next = S_DM;  end
      S_DM:  begin cmd.op = OP_DM;  state_next = S_WDM; end
      S_WDM: begin
        if (stat.div_done) begin cmd.op = OP_DV; state_next = S_WDV; end
      end
      S_WDV: begin
        if (stat.div_done) begin cmd.op = OP_SQ; state_next = S_WSQ; end
      end
      S_WSQ: begin
        if (stat.sqrt_done) begin cmd.op = OP_DQ; state_next = S_WDQ; end
      end
      S_WDQ: begin
        if (stat.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin cmd.op = OP_FIN; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.op == OP_FIN) out_valid <= 1'b1;
      else if (!out_stall)  out_valid <= 1'b0;
    end
  end

  `ADAM_ASSERT_NXT(a_accept_starts, in_valid && !in_stall, state == S_PW1, "accept did not start an item")
  `ADAM_ASSERT_NXT(a_fin_fills_out, cmd.op == OP_FIN, out_valid, "result beat not presented")
  `ADAM_ASSERT_NXT(a_wdq_to_fin, state == S_WDQ && stat.div_done, state == S_FIN, "quotient lost")

endmodule

/* sv/adam_optimizer_update_core.sv */
// Per-weight Adam update in fixed point. Each input beat carries a signed
// Q16.16 gradient, a weight index and an advance_step bit; the block
// optionally advances both beta powers, updates the first and second moment
// entries of that weight, bias-corrects them, and returns one output beat:
// m_hat / (sqrt(v_hat) + epsilon) as signed Q16.16 plus a saturated flag
// (set when a moment, a corrected moment or the result was clipped; a zero
// denominator returns zero with the flag clear). One item is in flight at a
// time; each runs three 48-step divisions on the one-bit-per-cycle divider
// and a 32-step square root, plus the beta power steps when advance_step is
// set. A finished beat waits in an output register, so the next item is
// accepted while it waits. After reset the moment stores are zeroed by a
// clearing pass over all 1024 entries, during which in_stall stays
// high. Registers over APB:
// 0x0 beta_first (Q0.16), 0x4 beta_second (Q0.16), 0x8 epsilon (Q16.16);
// low 16 bits kept. Write them only while the block is idle.
module adam_optimizer_update_core (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  adam_pkg::in_beat_t  in_data,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output adam_pkg::out_beat_t out_data,
  // APB configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import adam_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.beta_first  <= 16'd58982;
      cfg.beta_second <= 16'd65470;
      cfg.epsilon     <= 16'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_BETA_FIRST:  cfg.beta_first  <= pwdata[15:0];
        REG_BETA_SECOND: cfg.beta_second <= pwdata[15:0];
        REG_EPSILON:     cfg.epsilon     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BETA_FIRST:  prdata = {16'b0, cfg.beta_first};
      REG_BETA_SECOND: prdata = {16'b0, cfg.beta_second};
      REG_EPSILON:     prdata = {16'b0, cfg.epsilon};
      default:         prdata = '0;
    endcase
  end

  // sequencer: clear pass, then one item at a time
  adam_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // moment stores, shared multiplier, divider and root
  adam_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
